@@ rtl/core/dqs_pkg.sv @@
package dqs_pkg;

  localparam int DEPTH  = 16;
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int SUM_W  = CNT_W + 1;
  localparam int DATA_W = 32;

  localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [2:0] CMD_POP_BACK   = 3'd3;
  localparam logic [2:0] CMD_SEARCH     = 3'd4;
  localparam logic [2:0] CMD_DUMP       = 3'd5;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  typedef struct packed {
    logic        [2:0]        cmd;
    logic signed [DATA_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] data;
    logic                     found;
    logic        [1:0]        status;
    logic                     last;
  } rsp_t;

  // Slot of the entry at a given offset from the front, wrapped once.
  function automatic logic [IDX_W-1:0] slot_add(logic [IDX_W-1:0] base,
                                                logic [CNT_W-1:0] off);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(off);
    if (sum >= SUM_W'(DEPTH)) begin
      sum = sum - SUM_W'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

@@ rtl/core/dqs_ram.sv @@
module dqs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/deque_with_search_unit.sv @@
// Channel   | Handshake                 | Payload        | Notes
// ----------+---------------------------+----------------+------------------------------
// request   | start & !busy             | req (req_t)    | one command per request
// result    | result_strobe, one cycle  | result (rsp_t) | last marks final result
//
// Push (also on a full queue), and pop, search or dump on an empty queue, answer
// from idle; pop answers from S_POP after the RAM read; search and dump walk S_SCAN,
// one stored entry per cycle through the single read port of the entry RAM
// and the one shared comparator. Results appear in the cycle after they are formed.
// Reset (rst, synchronous) empties the queue; entries are not cleared.
// The result side cannot stall: each result is shown for exactly one cycle.
module deque_with_search_unit
  import dqs_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  req_t req,
  output rsp_t result,
  output logic result_strobe
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_POP  = 3'b010,
    S_SCAN = 3'b100
  } state_t;

  state_t state, state_next;

  logic [IDX_W-1:0]  front, front_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [CNT_W-1:0]  ptr, ptr_next;
  logic              hit, hit_next;
  logic              is_dump, is_dump_next;
  logic [DATA_W-1:0] key, key_next;
  rsp_t              result_next;
  logic              result_strobe_next;

  // Entry RAM ports
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic [IDX_W-1:0]  ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  logic accept;
  logic full;
  logic empty;
  logic match;
  logic scan_done;

  dqs_ram #(
    .WIDTH(DATA_W),
    .DEPTH(DEPTH)
  ) u_entries (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;
  assign full      = (count == CNT_W'(DEPTH));
  assign empty     = (count == '0);
  // Shared comparator: checks the entry read back in the previous cycle.
  assign match     = (ram_rdata == key);
  assign scan_done = (ptr == count);

  always_comb begin
    state_next         = state;
    front_next         = front;
    count_next         = count;
    ptr_next           = ptr;
    hit_next           = hit;
    is_dump_next       = is_dump;
    key_next           = key;
    result_next        = '0;
    result_strobe_next = 1'b0;
    ram_we             = 1'b0;
    ram_waddr          = '0;
    ram_wdata          = req.value;
    ram_raddr          = '0;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          result_next.last = 1'b1;
          unique case (req.cmd)
            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
              result_strobe_next = 1'b1;
              if (full) begin
                // Drop the push and report full.
                result_next.status = STAT_FULL;
              end else begin
                ram_we = 1'b1;
                if (req.cmd == CMD_PUSH_FRONT) begin
                  front_next = (front == '0) ? IDX_W'(DEPTH - 1) : front - 1'b1;
                  ram_waddr  = front_next;
                end else begin
                  ram_waddr = slot_add(front, count);
                end
                count_next = count + 1'b1;
              end
            end
            CMD_POP_FRONT, CMD_POP_BACK: begin
              if (empty) begin
                result_strobe_next = 1'b1;
                result_next.status = STAT_EMPTY;
              end else begin
                // Issue the read now; S_POP takes the data from the RAM.
                if (req.cmd == CMD_POP_FRONT) begin
                  ram_raddr  = front;
                  front_next = (front == IDX_W'(DEPTH - 1)) ? '0 : front + 1'b1;
                end else begin
                  ram_raddr = slot_add(front, count - 1'b1);
                end
                count_next = count - 1'b1;
                state_next = S_POP;
              end
            end
            CMD_SEARCH, CMD_DUMP: begin
              if (empty) begin
                // Empty search reports not found; empty dump reports empty.
                result_strobe_next = 1'b1;
                if (req.cmd == CMD_DUMP) begin
                  result_next.status = STAT_EMPTY;
                end
              end else begin
                // Read the front entry and start the walk at offset one.
                ram_raddr    = front;
                ptr_next     = CNT_W'(1);
                hit_next     = 1'b0;
                is_dump_next = (req.cmd == CMD_DUMP);
                key_next     = req.value;
                state_next   = S_SCAN;
              end
            end
            default: begin
              // Unused codes: drop the request silently.
            end
          endcase
        end
      end
      S_POP: begin
        result_strobe_next = 1'b1;
        result_next.data   = $signed(ram_rdata);
        result_next.last   = 1'b1;
        state_next         = S_IDLE;
      end
      S_SCAN: begin
        hit_next = hit | match;
        if (is_dump) begin
          result_strobe_next = 1'b1;
          result_next.data   = $signed(ram_rdata);
          result_next.last   = scan_done;
        end else if (scan_done) begin
          result_strobe_next = 1'b1;
          result_next.found  = hit | match;
          result_next.last   = 1'b1;
        end
        if (scan_done) begin
          state_next = S_IDLE;
        end else begin
          // Advance to the next stored entry.
          ram_raddr = slot_add(front, ptr);
          ptr_next  = ptr + 1'b1;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      front         <= '0;
      count         <= '0;
      result_strobe <= 1'b0;
    end else begin
      state         <= state_next;
      front         <= front_next;
      count         <= count_next;
      result_strobe <= result_strobe_next;
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    ptr     <= ptr_next;
    hit     <= hit_next;
    is_dump <= is_dump_next;
    key     <= key_next;
    result  <= result_next;
  end

endmodule

@@ rtl/core/dqs_checker.sv @@
module dqs_checker
  import dqs_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input req_t req,
  input rsp_t result,
  input logic result_strobe
);

  // A push always answers in the next cycle as the final result, never empty.
  a_push_answers: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (req.cmd == CMD_PUSH_FRONT || req.cmd == CMD_PUSH_BACK))
    |=> (result_strobe && result.last && result.status != STAT_EMPTY))
    else $error("push did not answer in the next cycle");

  // Dump results come back to back until the last one.
  a_dump_contiguous: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && !result.last) |=> result_strobe)
    else $error("gap inside a multi-result answer");

  // More results pending means the unit still refuses requests.
  a_busy_midstream: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && !result.last) |-> busy)
    else $error("request port open while results are pending");

  // A hit is only reported with ok status and zero data.
  a_found_clean: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && result.found)
    |-> (result.status == STAT_OK && result.data == '0))
    else $error("found flag with bad status or data");

endmodule

bind deque_with_search_unit dqs_checker u_dqs_checker (.*);
